// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	localparam logic [2:0] K_TICK  = 3'd0;
	localparam logic [2:0] K_START = 3'd1;
	localparam logic [2:0] K_STOP  = 3'd2;
	localparam logic [2:0] K_WRITE = 3'd3;
	localparam logic [2:0] K_READ  = 3'd4;
	localparam logic [2:0] K_WAIT  = 3'd5;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0]  ACK_TIMEOUT_RST     = 8'd100;
	localparam logic [15:0] TICKS_PER_PHASE_RST = 16'd1;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       accepted;
		logic [7:0] rx_byte;
		logic       ack_error;
	} result_t;

	typedef struct packed {
		logic       is_tick;
		logic       is_cmd;
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} cls_item_t;

	typedef struct packed {
		logic [7:0]  ack_timeout;
		logic [15:0] ticks_per_phase;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/i2cm_fifo.sv =====
// Small register queue with a registered head, used between the block's parts.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2cm_front.sv =====
// Front part: classifies incoming items and queues them for the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front import i2cm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t item,
	output logic       full,
	input  wire logic  head_pop,
	output cls_item_t  head,
	output logic       head_valid
);

	cls_item_t                    cls;
	logic [$bits(cls_item_t)-1:0] head_bits;
	logic                         q_empty;

	always_comb begin
		cls.kind     = item.kind;
		cls.tx_byte  = item.tx_byte;
		cls.send_ack = item.send_ack;
		cls.sda_in   = item.sda_in;
		cls.is_tick  = 1'b0;
		cls.is_cmd   = 1'b0;
		unique case (item.kind)
			K_TICK: cls.is_tick = 1'b1;
			K_START, K_STOP, K_WRITE, K_READ, K_WAIT: cls.is_cmd = 1'b1;
			default: ;
		endcase
	end

	i2cm_fifo #(
		.WIDTH($bits(cls_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (head_pop),
		.rdata (head_bits),
		.empty (q_empty)
	);

	assign head       = cls_item_t'(head_bits);
	assign head_valid = !q_empty;

endmodule

`default_nettype wire

// ===== hdl/i2cm_back.sv =====
// Back part: bus sequencer that steps the SCL/SDA waveform one item at a time.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back import i2cm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire cls_item_t head,
	input  wire logic      head_valid,
	output logic           head_pop,
	input  wire logic      res_full,
	output logic           res_push,
	output result_t        res
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_A    = 3'd1;
	localparam logic [2:0] PH_B    = 3'd2;
	localparam logic [2:0] PH_C    = 3'd3;
	localparam logic [2:0] PH_D    = 3'd4;
	localparam logic [3:0] BITS    = 4'd8;

	logic [2:0]  phase_q, phase_n;
	logic [2:0]  cmd_q, cmd_n;
	logic [3:0]  bit_cnt_q, bit_cnt_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] ticks_q, ticks_n;
	logic [7:0]  poll_q, poll_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        ack_err_q, ack_err_n;
	logic        ack_sel_q, ack_sel_n;
	logic [7:0]  rx_q, rx_n;
	logic [15:0] limit;
	logic        take;
	logic        adv;
	logic        fin;
	logic        acc;

	assign take     = head_valid && !res_full;
	assign head_pop = take;
	assign res_push = take;
	assign limit    = (cfg.ticks_per_phase == '0) ? 16'd1 : cfg.ticks_per_phase;

	always_comb begin
		phase_n   = phase_q;
		cmd_n     = cmd_q;
		bit_cnt_n = bit_cnt_q;
		shift_n   = shift_q;
		ticks_n   = ticks_q;
		poll_n    = poll_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		ack_err_n = ack_err_q;
		ack_sel_n = ack_sel_q;
		rx_n      = rx_q;
		adv       = 1'b0;
		fin       = 1'b0;
		acc       = 1'b0;
		if (head.is_tick) begin
			if (phase_q != PH_IDLE) begin
				if (cmd_q == K_WAIT && phase_q == PH_B) begin
					adv = 1'b1;
				end else begin
					ticks_n = ticks_q + 16'd1;
					if (ticks_n >= limit) begin
						ticks_n = '0;
						adv     = 1'b1;
					end
				end
			end
			if (adv) begin
				unique case (cmd_q)
					K_START: begin
						if (phase_q == PH_A) begin
							sda_n   = 1'b0;
							phase_n = PH_B;
						end else begin
							scl_n = 1'b0;
							fin   = 1'b1;
						end
					end
					K_STOP: begin
						if (phase_q == PH_A) begin
							scl_n   = 1'b1;
							phase_n = PH_B;
						end else if (phase_q == PH_B) begin
							sda_n   = 1'b1;
							phase_n = PH_C;
						end else begin
							fin = 1'b1;
						end
					end
					K_WRITE: begin
						if (phase_q == PH_A) begin
							scl_n   = 1'b1;
							phase_n = PH_B;
						end else if (phase_q == PH_B) begin
							scl_n   = 1'b0;
							phase_n = PH_C;
						end else begin
							bit_cnt_n = bit_cnt_q + 4'd1;
							if (bit_cnt_n < BITS) begin
								sda_n   = shift_q[7];
								shift_n = {shift_q[6:0], 1'b0};
								phase_n = PH_A;
							end else begin
								fin = 1'b1;
							end
						end
					end
					K_READ: begin
						if (phase_q == PH_A) begin
							scl_n   = 1'b1;
							phase_n = PH_B;
						end else if (phase_q == PH_B) begin
							shift_n   = {shift_q[6:0], head.sda_in};
							bit_cnt_n = bit_cnt_q + 4'd1;
							scl_n     = 1'b0;
							if (bit_cnt_n < BITS) begin
								sda_n   = 1'b1;
								phase_n = PH_A;
							end else begin
								rx_n    = shift_n;
								sda_n   = ~ack_sel_q;
								phase_n = PH_C;
							end
						end else if (phase_q == PH_C) begin
							scl_n   = 1'b1;
							phase_n = PH_D;
						end else begin
							scl_n = 1'b0;
							fin   = 1'b1;
						end
					end
					K_WAIT: begin
						if (phase_q == PH_A) begin
							phase_n = PH_B;
						end
						if (!head.sda_in) begin
							scl_n = 1'b0;
							fin   = 1'b1;
						end else if (poll_q >= cfg.ack_timeout) begin
							ack_err_n = 1'b1;
							scl_n     = 1'b0;
							cmd_n     = K_STOP;
							sda_n     = 1'b0;
							phase_n   = PH_A;
							ticks_n   = '0;
						end else begin
							poll_n = poll_q + 8'd1;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			if (fin) begin
				phase_n = PH_IDLE;
			end
		end else if (head.is_cmd && phase_q == PH_IDLE) begin
			acc       = 1'b1;
			cmd_n     = head.kind;
			phase_n   = PH_A;
			ticks_n   = '0;
			bit_cnt_n = '0;
			unique case (head.kind)
				K_START: begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end
				K_STOP: sda_n = 1'b0;
				K_WRITE: begin
					scl_n   = 1'b0;
					sda_n   = head.tx_byte[7];
					shift_n = {head.tx_byte[6:0], 1'b0};
				end
				K_READ: begin
					scl_n     = 1'b0;
					sda_n     = 1'b1;
					shift_n   = '0;
					ack_sel_n = head.send_ack;
				end
				default: begin
					scl_n     = 1'b1;
					sda_n     = 1'b1;
					poll_n    = '0;
					ack_err_n = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res.scl       = scl_n;
		res.sda_out   = sda_n;
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = fin;
		res.accepted  = acc;
		res.rx_byte   = rx_n;
		res.ack_error = ack_err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cmd_q     <= K_TICK;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			ticks_q   <= '0;
			poll_q    <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_err_q <= 1'b0;
			ack_sel_q <= 1'b0;
			rx_q      <= '0;
		end else if (take) begin
			phase_q   <= phase_n;
			cmd_q     <= cmd_n;
			bit_cnt_q <= bit_cnt_n;
			shift_q   <= shift_n;
			ticks_q   <= ticks_n;
			poll_q    <= poll_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			ack_err_q <= ack_err_n;
			ack_sel_q <= ack_sel_n;
			rx_q      <= rx_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: config registers, front, sequencer, result queue.
//
// Usage:
//   Items (ticks and commands) enter as a queue: push an item while full is low.
//   Results leave as a queue: while empty is low the oldest result is on result;
//   pop it to complete the transfer. Every item yields exactly one result.
//   Tick items step the SCL/SDA waveform; commands issued while a bus sequence
//   runs come back with accepted low.
//   Path: an accepted item is registered in the input queue; the sequencer takes it
//   from the head while the result queue has room, and its result is registered in
//   the result queue, where it shows on result and can be popped.
//   Throughput: one item per clock while the result queue has room; the sequencer
//   retires one item per cycle from the input queue into the result queue.
//   Queues of QUEUE_DEPTH entries sit on both sides, so a stalled receiver
//   fills the result queue, then the input queue, and only then raises full.
//   Configuration (ack_timeout at 0x0, ticks_per_phase at 0x4) is written over the APB
//   port by the user only while the engine is idle; the block leaves that unchecked.
//   Reset empties both queues, releases SCL and SDA high, and loads
//   ack_timeout = 100 and ticks_per_phase = 1. pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine_core import i2cm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire item_t       item,
	output logic             full,
	output logic             empty,
	input  wire logic        pop,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic REG_ACK_TIMEOUT     = 1'b0;
	localparam logic REG_TICKS_PER_PHASE = 1'b1;

	logic [7:0]                 ack_timeout_q;
	logic [15:0]                ticks_per_phase_q;
	cfg_t                       cfg;
	cls_item_t                  head;
	logic                       head_valid;
	logic                       head_pop;
	logic                       res_push;
	logic                       res_full;
	result_t                    res;
	logic [$bits(result_t)-1:0] res_bits;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q     <= ACK_TIMEOUT_RST;
			ticks_per_phase_q <= TICKS_PER_PHASE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ACK_TIMEOUT:     ack_timeout_q     <= pwdata[7:0];
				REG_TICKS_PER_PHASE: ticks_per_phase_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACK_TIMEOUT:     prdata = {24'd0, ack_timeout_q};
			REG_TICKS_PER_PHASE: prdata = {16'd0, ticks_per_phase_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.ack_timeout     = ack_timeout_q;
	assign cfg.ticks_per_phase = ticks_per_phase_q;

	i2cm_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.head_pop  (head_pop),
		.head      (head),
		.head_valid(head_valid)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	i2cm_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign result = result_t'(res_bits);

endmodule

`default_nettype wire

// ===== hdl/i2cm_checker.sv =====
// Port-level checker for the I2C master bit engine and its bind.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker import i2cm_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.accepted |-> result.busy_res)
		else $error("accepted command without busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.done_res |-> !result.busy_res && !result.accepted)
		else $error("done result still busy or accepted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed before transfer");

	a_reset_empty: assert property (@(posedge clk)
		$past(!arst_n) |-> empty)
		else $error("result queue not empty after reset");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_i2cm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

`default_nettype wire

// ===== tb/i2c_master_bit_engine_core_tb.sv =====
// Self-checking testbench for the I2C master bit engine: queued items, APB config, predicted results.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_tb;
	import i2cm_pkg::*;

	localparam logic [3:0] POLL_PHASE = 4'd2;
	localparam int REG_ACK_TIMEOUT = 0;
	localparam int REG_TICKS_PER_PHASE = 1;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int ENGINE_SETTLE = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	item_t item = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	i2c_master_bit_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// engine copy: configuration and bus sequencer state
	logic [7:0] cfg_timeout;
	logic [15:0] cfg_tpp;
	logic [3:0] bus_phase;
	logic [2:0] cur_cmd;
	logic [3:0] nbits;
	logic [7:0] shreg;
	logic [15:0] tick_cnt;
	logic [7:0] polls;
	logic scl_q, sda_q, ack_err_q, ack_sel;
	logic [7:0] rx_q;

	result_t pending_results[$];
	result_t want_res;

	int errors = 0;
	int item_count = 0;
	int work_items = 0;
	int reg_writes = 0;
	int ack_aborts = 0;
	int done_count = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int noise_pct = 8;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void engine_reset();
		cfg_timeout = ACK_TIMEOUT_RST;
		cfg_tpp = TICKS_PER_PHASE_RST;
		bus_phase = '0;
		cur_cmd = '0;
		nbits = '0;
		shreg = '0;
		tick_cnt = '0;
		polls = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		ack_err_q = 1'b0;
		ack_sel = 1'b0;
		rx_q = '0;
	endfunction

	function automatic void shift_out();
		sda_q = shreg[7];
		shreg = shreg << 1;
	endfunction

	function automatic logic phase_end(input logic sda);
		case (cur_cmd)
		K_START: begin
			if (bus_phase == 4'd1) begin
				sda_q = 1'b0;
				bus_phase = 4'd2;
				return 1'b0;
			end
			scl_q = 1'b0;
			return 1'b1;
		end
		K_STOP: begin
			if (bus_phase == 4'd1) begin
				scl_q = 1'b1;
				bus_phase = 4'd2;
				return 1'b0;
			end
			if (bus_phase == 4'd2) begin
				sda_q = 1'b1;
				bus_phase = 4'd3;
				return 1'b0;
			end
			return 1'b1;
		end
		K_WRITE: begin
			if (bus_phase == 4'd1) begin
				scl_q = 1'b1;
				bus_phase = 4'd2;
				return 1'b0;
			end
			if (bus_phase == 4'd2) begin
				scl_q = 1'b0;
				bus_phase = 4'd3;
				return 1'b0;
			end
			nbits = nbits + 4'd1;
			if (nbits < 4'd8) begin
				shift_out();
				bus_phase = 4'd1;
				return 1'b0;
			end
			return 1'b1;
		end
		K_READ: begin
			if (bus_phase == 4'd1) begin
				scl_q = 1'b1;
				bus_phase = 4'd2;
				return 1'b0;
			end
			if (bus_phase == 4'd2) begin
				shreg = {shreg[6:0], sda};
				nbits = nbits + 4'd1;
				scl_q = 1'b0;
				if (nbits < 4'd8) begin
					sda_q = 1'b1;
					bus_phase = 4'd1;
				end else begin
					rx_q = shreg;
					sda_q = ack_sel ? 1'b0 : 1'b1;
					bus_phase = 4'd3;
				end
				return 1'b0;
			end
			if (bus_phase == 4'd3) begin
				scl_q = 1'b1;
				bus_phase = 4'd4;
				return 1'b0;
			end
			scl_q = 1'b0;
			return 1'b1;
		end
		K_WAIT: begin
			if (bus_phase == 4'd1)
				bus_phase = POLL_PHASE;
			if (!sda) begin
				scl_q = 1'b0;
				return 1'b1;
			end
			if (polls >= cfg_timeout) begin
				ack_err_q = 1'b1;
				scl_q = 1'b0;
				cur_cmd = K_STOP;
				sda_q = 1'b0;
				bus_phase = 4'd1;
				tick_cnt = '0;
				ack_aborts++;
				return 1'b0;
			end
			polls = polls + 8'd1;
			return 1'b0;
		end
		default: return 1'b1;
		endcase
	endfunction

	function automatic result_t predict_result(input item_t it);
		result_t r;
		logic fin;
		logic [15:0] lim;
		r = '0;
		fin = 1'b0;
		lim = (cfg_tpp == 16'd0) ? 16'd1 : cfg_tpp;
		if (it.kind == K_TICK) begin
			if (bus_phase != 4'd0) begin
				if (cur_cmd == K_WAIT && bus_phase == POLL_PHASE) begin
					fin = phase_end(it.sda_in);
				end else begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= lim) begin
						tick_cnt = '0;
						fin = phase_end(it.sda_in);
					end
				end
				if (fin) begin
					bus_phase = '0;
					r.done_res = 1'b1;
				end
			end
		end else if (it.kind <= K_WAIT && bus_phase == 4'd0) begin
			r.accepted = 1'b1;
			cur_cmd = it.kind;
			bus_phase = 4'd1;
			tick_cnt = '0;
			nbits = '0;
			case (it.kind)
			K_START: begin
				scl_q = 1'b1;
				sda_q = 1'b1;
			end
			K_STOP: sda_q = 1'b0;
			K_WRITE: begin
				scl_q = 1'b0;
				shreg = it.tx_byte;
				shift_out();
			end
			K_READ: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
				shreg = '0;
				ack_sel = it.send_ack;
			end
			default: begin
				scl_q = 1'b1;
				sda_q = 1'b1;
				polls = '0;
				ack_err_q = 1'b0;
			end
			endcase
		end
		r.scl = scl_q;
		r.sda_out = sda_q;
		r.busy_res = (bus_phase != 4'd0);
		r.rx_byte = rx_q;
		r.ack_error = ack_err_q;
		return r;
	endfunction

	function automatic item_t rand_item(input logic [2:0] kind);
		item_t it;
		it.kind = kind;
		it.tx_byte = 8'($urandom);
		it.send_ack = 1'($urandom);
		it.sda_in = 1'($urandom);
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endtask

	task automatic send_item(input item_t it);
		logic was_busy;
		result_t res;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full);
		was_busy = (bus_phase != 4'd0);
		res = predict_result(it);
		pending_results.push_back(res);
		item_count++;
		if (res.done_res)
			done_count++;
		if (res.accepted || (it.kind == K_TICK && was_busy))
			work_items++;
	endtask

	task automatic send_tick(input int low_pct);
		item_t it;
		it = rand_item(K_TICK);
		it.sda_in = ($urandom_range(99) >= low_pct);
		send_item(it);
	endtask

	task automatic finish_sequence(input int low_pct);
		while (bus_phase != 4'd0) begin
			if ($urandom_range(99) < noise_pct)
				send_item(rand_item(3'($urandom_range(7, 1))));
			else
				send_tick(low_pct);
		end
	endtask

	task automatic run_command(input logic [2:0] kind, input logic [7:0] tx, input logic ack,
			input int low_pct);
		item_t it;
		it = rand_item(kind);
		it.tx_byte = tx;
		it.send_ack = ack;
		send_item(it);
		finish_sequence(low_pct);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_read_check(input int idx);
		logic [15:0] want, got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_ACK_TIMEOUT) begin
			got = {8'h00, prdata[7:0]};
			want = {8'h00, cfg_timeout};
		end else begin
			got = prdata[15:0];
			want = cfg_tpp;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report_mismatch(idx == REG_ACK_TIMEOUT ? "ack_timeout readback" :
				"ticks_per_phase readback", 32'(want), 32'(got));
	endtask

	task automatic cfg_write(input int idx, input logic [15:0] value);
		logic [31:0] data;
		drain();
		repeat (ENGINE_SETTLE) @(posedge clk);
		data = $urandom;
		if (idx == REG_ACK_TIMEOUT) begin
			data[7:0] = value[7:0];
			cfg_timeout = value[7:0];
		end else begin
			data[15:0] = value;
			cfg_tpp = value;
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		@(posedge clk);
		cfg_read_check(idx);
	endtask

	task automatic random_transaction();
		int low;
		if ($urandom_range(99) < 10) begin
			send_item(rand_item(3'($urandom_range(7))));
			finish_sequence(50);
		end else begin
			run_command(K_START, 8'($urandom), 1'($urandom), 50);
			run_command(K_WRITE, 8'($urandom), 1'($urandom), 50);
			low = ($urandom_range(3) == 0) ? 0 : $urandom_range(70, 10);
			run_command(K_WAIT, 8'($urandom), 1'($urandom), low);
			repeat ($urandom_range(2)) begin
				low = ($urandom_range(3) == 0) ? 0 : $urandom_range(70, 10);
				case ($urandom_range(2))
				0: run_command(K_WRITE, 8'($urandom), 1'($urandom), 50);
				1: run_command(K_READ, 8'($urandom), 1'($urandom), 50);
				default: run_command(K_WAIT, 8'($urandom), 1'($urandom), low);
				endcase
			end
			run_command(K_STOP, 8'($urandom), 1'($urandom), 50);
		end
	endtask

	task automatic test_directed_commands();
		item_t it;
		send_tick(50);
		send_item(rand_item(3'd6));
		send_item(rand_item(3'd7));
		it = rand_item(K_START);
		send_item(it);
		send_item(rand_item(K_STOP));
		finish_sequence(50);
		run_command(K_WRITE, 8'hFF, 1'b0, 50);
		run_command(K_WRITE, 8'h00, 1'b1, 50);
		run_command(K_WAIT, 8'h00, 1'b0, 100);
		run_command(K_READ, 8'h00, 1'b1, 0);
		run_command(K_READ, 8'hFF, 1'b0, 100);
		run_command(K_STOP, 8'h5A, 1'b1, 50);
	endtask

	task automatic test_register_extremes();
		drain();
		cfg_read_check(REG_ACK_TIMEOUT);
		cfg_read_check(REG_TICKS_PER_PHASE);
		cfg_write(REG_ACK_TIMEOUT, 16'd0);
		cfg_write(REG_TICKS_PER_PHASE, 16'd0);
		run_command(K_WAIT, 8'h00, 1'b0, 0);
		run_command(K_WAIT, 8'h00, 1'b0, 100);
		run_command(K_WRITE, 8'hA5, 1'b1, 50);
		cfg_write(REG_ACK_TIMEOUT, 16'd255);
		cfg_write(REG_TICKS_PER_PHASE, 16'd1);
		run_command(K_WAIT, 8'h00, 1'b0, 0);
		cfg_write(REG_TICKS_PER_PHASE, 16'hFFFF);
		send_tick(50);
	endtask

	task automatic test_full_stall();
		int saved;
		saved = send_idle;
		send_idle = 0;
		drain();
		hold_req++;
		run_command(K_WRITE, 8'($urandom), 1'b0, 50);
		run_command(K_READ, 8'($urandom), 1'($urandom), 50);
		drain();
		send_idle = saved;
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
		int goal;
		logic paused;
		send_idle = send_pct;
		recv_idle = recv_pct;
		cfg_write(REG_ACK_TIMEOUT, 16'($urandom_range(12)));
		cfg_write(REG_TICKS_PER_PHASE, 16'($urandom_range(2)));
		goal = work_items + target;
		paused = 1'b0;
		while (work_items < goal) begin
			random_transaction();
			if (!paused && work_items >= goal - target / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, actual %0h",
						$time, result);
				end else begin
					want_res = pending_results.pop_front();
					if (result.scl !== want_res.scl)
						report_mismatch("scl", 32'(want_res.scl), 32'(result.scl));
					if (result.sda_out !== want_res.sda_out)
						report_mismatch("sda_out", 32'(want_res.sda_out),
							32'(result.sda_out));
					if (result.busy_res !== want_res.busy_res)
						report_mismatch("busy_res", 32'(want_res.busy_res),
							32'(result.busy_res));
					if (result.done_res !== want_res.done_res)
						report_mismatch("done_res", 32'(want_res.done_res),
							32'(result.done_res));
					if (result.accepted !== want_res.accepted)
						report_mismatch("accepted", 32'(want_res.accepted),
							32'(result.accepted));
					if (result.rx_byte !== want_res.rx_byte)
						report_mismatch("rx_byte", 32'(want_res.rx_byte),
							32'(result.rx_byte));
					if (result.ack_error !== want_res.ack_error)
						report_mismatch("ack_error", 32'(want_res.ack_error),
							32'(result.ack_error));
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("i2c_master_bit_engine_core regression: fail");
		$finish;
	end

	initial begin
		engine_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_register_extremes();
		test_random_traffic(32, 70, 70);
		test_full_stall();
		test_random_traffic(70, 32, 70);
		test_random_traffic(0, 0, 70);
		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d items (%0d driving the bus), %0d finished commands, %0d ack aborts",
			item_count, work_items, done_count, ack_aborts);
		$display("with %0d register writes and three idle patterns on both queues",
			reg_writes);
		if (errors == 0)
			$display("i2c_master_bit_engine_core regression: pass");
		else
			$display("i2c_master_bit_engine_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_fifo.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine_core.sv
hdl/i2cm_checker.sv
tb/i2c_master_bit_engine_core_tb.sv
